[hdl/ece_pkg.sv]
package ece_pkg;

	// Widths of the transfer fields.
	localparam int unsigned CmdW  = 4;
	localparam int unsigned PosW  = 16;
	localparam int unsigned TimeW = 16;
	localparam int unsigned FracW = 16;

	// Curve selector codes.
	localparam logic [CmdW-1:0] CMD_QUAD_IN    = 4'd0;
	localparam logic [CmdW-1:0] CMD_QUAD_OUT   = 4'd1;
	localparam logic [CmdW-1:0] CMD_QUAD_INOUT = 4'd2;
	localparam logic [CmdW-1:0] CMD_CUBE_IN    = 4'd3;
	localparam logic [CmdW-1:0] CMD_CUBE_OUT   = 4'd4;
	localparam logic [CmdW-1:0] CMD_CUBE_INOUT = 4'd5;
	localparam logic [CmdW-1:0] CMD_QURT_IN    = 4'd6;
	localparam logic [CmdW-1:0] CMD_QURT_OUT   = 4'd7;
	localparam logic [CmdW-1:0] CMD_QURT_INOUT = 4'd8;
	localparam logic [CmdW-1:0] CMD_SINE_IN    = 4'd9;
	localparam logic [CmdW-1:0] CMD_SINE_OUT   = 4'd10;
	localparam logic [CmdW-1:0] CMD_SINE_INOUT = 4'd11;
	localparam logic [CmdW-1:0] CMD_CIRC_IN    = 4'd12;
	localparam logic [CmdW-1:0] CMD_CIRC_OUT   = 4'd13;
	localparam logic [CmdW-1:0] CMD_CIRC_INOUT = 4'd14;
	localparam logic [CmdW-1:0] CMD_LINEAR     = 4'd15;

	// Sine polynomial coefficients in Q30.
	localparam logic [31:0] SinC1 = 32'd1686629713;
	localparam logic [31:0] SinC3 = 32'd693598668;
	localparam logic [31:0] SinC5 = 32'd85569306;
	localparam logic [31:0] SinC7 = 32'd5026991;
	localparam logic [31:0] SinC9 = 32'd172272;

	typedef struct packed {
		logic [CmdW-1:0]         command;
		logic signed [PosW-1:0]  start_value;
		logic signed [PosW-1:0]  span;
		logic [TimeW-1:0]        elapsed_ticks;
		logic [TimeW-1:0]        total_ticks;
	} ece_in_t;

	typedef struct packed {
		logic signed [PosW-1:0] eased_value;
		logic                   clipped;
		logic                   bad_duration;
	} ece_out_t;

endpackage

[hdl/ece_div_cell.sv]
// One restoring step of the fraction divider: one quotient bit per cell.
module ece_div_cell #(
	parameter int unsigned TW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [TW:0]           in_rem,
	input  logic [TW-1:0]         in_den,
	input  logic [TW+16:0]        in_quo,
	input  logic                  in_en,
	output logic                  out_valid,
	output logic [TW:0]           out_rem,
	output logic [TW-1:0]         out_den,
	output logic [TW+16:0]        out_quo
);
	logic [TW+1:0] trial;
	logic          take;

	// Trial subtract of the shifted remainder.
	assign trial = {in_rem, 1'b0} - {2'b00, in_den};
	assign take  = !trial[TW+1];

	// Valid bit of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_en) begin
			out_valid <= in_valid;
		end
	end

	// Data handed to the next cell.
	always_ff @(posedge clk) begin
		if (in_en) begin
			out_rem <= take ? trial[TW:0] : {in_rem[TW-1:0], 1'b0};
			out_den <= in_den;
			out_quo <= {in_quo[TW+15:0], take};
		end
	end
endmodule

[hdl/ece_curve.sv]
// Eased fraction from the clamped linear fraction, in registered stages.
module ece_curve (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [ece_pkg::CmdW-1:0]  in_cmd,
	input  logic [16:0]               in_f,
	input  logic                      in_bad,
	input  logic signed [15:0]        in_start,
	input  logic signed [15:0]        in_span,
	output logic                      out_valid,
	output ece_pkg::ece_out_t         out_item
);
	import ece_pkg::*;

	localparam int unsigned NS = 14;
	localparam logic [16:0] One  = 17'h10000;
	localparam logic [16:0] Half = 17'h08000;

	typedef struct packed {
		logic [CmdW-1:0]    cmd;
		logic               bad;
		logic               lo;
		logic signed [15:0] start;
		logic signed [15:0] span;
		logic [16:0]        f;
	} meta_t;

	function automatic logic [16:0] fm(input logic [16:0] a, input logic [16:0] b);
		logic [33:0] p;
		p = a * b + 34'd32768;
		return p[32:16];
	endfunction

	meta_t       m_s [NS+1];
	logic        v_s [NS+1];
	logic [16:0] x_s [NS+1];
	logic [16:0] a_s [NS+1];
	logic [31:0] p_s [NS+1];
	logic [33:0] r_s [NS+1];
	logic [33:0] b_s [NS+1];
	logic [16:0] e_s [NS+1];

	logic [16:0] x_c, sq_c, a_c;
	logic [2:0]  kind;

	always_comb begin
		unique case (in_cmd)
			CMD_QUAD_IN, CMD_QUAD_OUT, CMD_QUAD_INOUT: kind = 3'd0;
			CMD_CUBE_IN, CMD_CUBE_OUT, CMD_CUBE_INOUT: kind = 3'd1;
			CMD_QURT_IN, CMD_QURT_OUT, CMD_QURT_INOUT: kind = 3'd2;
			CMD_SINE_IN, CMD_SINE_OUT, CMD_SINE_INOUT: kind = 3'd3;
			CMD_CIRC_IN, CMD_CIRC_OUT, CMD_CIRC_INOUT: kind = 3'd4;
			default:                                   kind = 3'd5;
		endcase
	end

	// Ahead of the stage 0 register: pick the base value for the curve.
	always_comb begin
		logic [16:0] g;
		logic        lo;
		g  = One - in_f;
		lo = in_f < Half;
		x_c = in_f;
		unique case (in_cmd)
			CMD_QUAD_OUT, CMD_CUBE_OUT, CMD_QURT_OUT, CMD_SINE_IN, CMD_CIRC_OUT: x_c = g;
			CMD_QUAD_INOUT, CMD_CUBE_INOUT, CMD_QURT_INOUT:
				x_c = lo ? in_f : g;
			CMD_SINE_INOUT: x_c = lo ? (One - {in_f[15:0], 1'b0}) : ({in_f[15:0], 1'b0} - One);
			CMD_CIRC_INOUT: x_c = lo ? {in_f[15:0], 1'b0} : {g[15:0], 1'b0};
			default:        x_c = in_f;
		endcase
		sq_c = fm(x_c, x_c);
		a_c  = (kind == 3'd4) ? (One - sq_c) : sq_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NS; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i <= NS; i++) v_s[i] <= v_s[i-1];
		end
	end

	// Stage 0 register: base value, its square and the square root operand.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= '{cmd: in_cmd, bad: in_bad, lo: in_f < Half, start: in_start,
				span: in_span, f: in_f};
			x_s[0] <= x_c;
			a_s[0] <= a_c;
			p_s[0] <= SinC9;
			e_s[0] <= x_c;
			r_s[0] <= '0;
			b_s[0] <= {1'b0, a_c, 16'd0};
		end
	end

	// Stages 1..NS: sine Horner steps, powers, and square root digits.
	for (genvar s = 1; s <= NS; s++) begin : g_st
		logic [31:0] p_n;
		logic [33:0] r_n, b_n;
		logic [16:0] e_n;

		always_comb begin
			logic [48:0] t;
			logic [63:0] rr, xx, bb;
			p_n = p_s[s-1];
			r_n = r_s[s-1];
			b_n = b_s[s-1];
			e_n = e_s[s-1];
			t   = '0;
			rr  = 64'(r_s[s-1]);
			xx  = 64'(b_s[s-1]);
			bb  = '0;
			unique case (s)
				1: begin
					t   = p_s[0] * a_s[0];
					p_n = SinC7 - t[47:16];
					e_n = fm(x_s[0], a_s[0]);
				end
				2: begin
					t   = p_s[1] * a_s[1];
					p_n = SinC5 - t[47:16];
					// The fourth power is built on the rounded cube.
					if (m_s[1].cmd == CMD_QURT_IN || m_s[1].cmd == CMD_QURT_OUT ||
							m_s[1].cmd == CMD_QURT_INOUT)
						e_n = fm(e_s[1], x_s[1]);
				end
				3: begin
					t   = p_s[2] * a_s[2];
					p_n = SinC3 - t[47:16];
				end
				4: begin
					t   = p_s[3] * a_s[3];
					p_n = SinC1 - t[47:16];
				end
				5: begin
					t   = p_s[4] * x_s[4];
					p_n = (t[48:30] > 19'(One)) ? 32'(One) : 32'(t[48:30]);
				end
				default: begin
					// Three square root digits per stage.
					bb = 64'd1 << (6 * (NS - s) + 4);
					for (int k = 0; k < 3; k++) begin
						if (xx >= rr + bb) begin
							xx = xx - (rr + bb);
							rr = (rr >> 1) + bb;
						end else begin
							rr = rr >> 1;
						end
						bb = bb >> 2;
					end
					r_n = rr[33:0];
					b_n = xx[33:0];
				end
			endcase
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[s] <= m_s[s-1];
				x_s[s] <= x_s[s-1];
				a_s[s] <= a_s[s-1];
				p_s[s] <= p_n;
				r_s[s] <= r_n;
				b_s[s] <= b_n;
				e_s[s] <= e_n;
			end
		end
	end

	// Final stage: pick the eased value, scale, add and saturate.
	logic [16:0]        e_c;
	logic [16:0]        sn, sq, p2, p3;
	logic signed [35:0] prod;
	logic signed [20:0] delta, sum;

	always_comb begin
		meta_t mm;
		mm = m_s[NS];
		sn = (x_s[NS] >= One) ? One : p_s[NS][16:0];
		sq = r_s[NS][16:0];
		p2 = a_s[NS];
		// Cube for cubic curves, fourth power for quartic curves.
		p3 = e_s[NS];
		unique case (mm.cmd)
			CMD_QUAD_IN:    e_c = p2;
			CMD_CUBE_IN:    e_c = p3;
			CMD_QURT_IN:    e_c = p3;
			CMD_QUAD_OUT:   e_c = One - p2;
			CMD_CUBE_OUT:   e_c = One - p3;
			CMD_QURT_OUT:   e_c = One - p3;
			CMD_QUAD_INOUT: e_c = mm.lo ? {p2[15:0], 1'b0} : One - {p2[15:0], 1'b0};
			CMD_CUBE_INOUT: e_c = mm.lo ? {p3[14:0], 2'b0} : One - {p3[14:0], 2'b0};
			CMD_QURT_INOUT: e_c = mm.lo ? {p3[13:0], 3'b0} : One - {p3[13:0], 3'b0};
			CMD_SINE_IN:    e_c = One - sn;
			CMD_SINE_OUT:   e_c = sn;
			CMD_SINE_INOUT: e_c = mm.lo ? ((One - sn) >> 1)
				: 17'((18'(One) + 18'(sn)) >> 1);
			CMD_CIRC_IN:    e_c = One - sq;
			CMD_CIRC_OUT:   e_c = sq;
			CMD_CIRC_INOUT: e_c = mm.lo ? ((One - sq) >> 1)
				: 17'((18'(One) + 18'(sq)) >> 1);
			default:        e_c = mm.f;
		endcase
		if (mm.bad) e_c = One;
		prod  = mm.span * $signed({1'b0, e_c}) + 36'sd32768;
		delta = 21'(prod >>> 16);
		sum   = 21'(mm.start) + delta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item.bad_duration <= m_s[NS].bad;
			out_item.clipped      <= (sum > 21'sd32767) || (sum < -21'sd32768);
			out_item.eased_value  <= (sum > 21'sd32767) ? 16'sh7fff :
				(sum < -21'sd32768) ? -16'sh8000 : sum[15:0];
		end
	end
endmodule

[hdl/easing_curve_evaluator_top.sv]
// Channel | direction | payload
// in      | into      | ece_in_t: command, start, span, elapsed, duration
// out     | out of    | ece_out_t: eased value, clipped, bad_duration
// One item enters per cycle while out is not stalled; results leave in order
// through the 16-cell divider chain and the 16 curve stages.
// The whole pipe advances when the output register is empty or taken, so a
// stall on out holds every stage. Reset clears all valid bits.
module easing_curve_evaluator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ece_pkg::ece_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ece_pkg::ece_out_t  out_data
);
	import ece_pkg::*;

	localparam int unsigned NC = FracW;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic          v_c [NC+1];
	logic [TimeW:0] r_c [NC+1];
	logic [TimeW-1:0] d_c [NC+1];
	logic [TimeW+16:0] q_c [NC+1];
	ece_in_t       it_q [NC+1];

	// Head of the divider chain: elapsed below duration keeps rem < den.
	assign v_c[0] = in_valid;
	assign r_c[0] = {1'b0, in_data.elapsed_ticks};
	assign d_c[0] = in_data.total_ticks;
	assign q_c[0] = '0;
	always_comb it_q[0] = in_data;

	for (genvar i = 0; i < NC; i++) begin : g_div
		ece_div_cell #(.TW(TimeW)) u_cell (
			.clk(clk), .arst_n(arst_n), .in_valid(v_c[i]), .in_rem(r_c[i]),
			.in_den(d_c[i]), .in_quo(q_c[i]), .in_en(en), .out_valid(v_c[i+1]),
			.out_rem(r_c[i+1]), .out_den(d_c[i+1]), .out_quo(q_c[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) it_q[i+1] <= it_q[i];
		end
	end

	// Clamp the fraction and flag a zero duration.
	logic [16:0] f_c;
	logic        bad_c;
	always_comb begin
		bad_c = (it_q[NC].total_ticks == '0);
		f_c   = (it_q[NC].elapsed_ticks >= it_q[NC].total_ticks) ? 17'h10000
			: {1'b0, q_c[NC][15:0]};
	end

	ece_curve u_curve (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_c[NC]),
		.in_cmd(it_q[NC].command), .in_f(f_c), .in_bad(bad_c),
		.in_start(it_q[NC].start_value), .in_span(it_q[NC].span),
		.out_valid(out_valid), .out_item(out_data)
	);
endmodule

[hdl/ece_checker.sv]
module ece_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input ece_pkg::ece_out_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input offer withdrawn before transfer");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("ready low with empty output");
endmodule

bind easing_curve_evaluator_top ece_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ece_pkg::*;

	localparam int unsigned One = 1 << FracW;
	localparam int unsigned Half = One >> 1;
	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles = 80;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ece_in_t in_data;
	logic out_valid;
	logic out_ready;
	ece_out_t out_data;

	easing_curve_evaluator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	ece_in_t pending_items[$];
	ece_out_t expected_positions[$];
	int errors = 0;
	int idle_mode = 0;
	int hold_off_cycles = 0;
	int quiet_cycles = 0;

	// Fraction product with rounding.
	function automatic longint unsigned frac_mul(longint unsigned a, longint unsigned b);
		return (a * b + Half) >> FracW;
	endfunction

	function automatic longint unsigned frac_pow(longint unsigned a, int n);
		longint unsigned r;
		r = a;
		for (int i = 1; i < n; i++) r = frac_mul(r, a);
		return r;
	endfunction

	// Bitwise integer square root of x scaled up by one fraction unit.
	function automatic longint unsigned frac_sqrt(longint unsigned x);
		longint unsigned v, r, b;
		v = x << FracW;
		r = 0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Quarter-wave sine by Horner evaluation of the Taylor polynomial.
	function automatic longint unsigned quarter_sine(longint unsigned u);
		longint unsigned u2, p;
		if (u >= One) return One;
		u2 = frac_mul(u, u);
		p = SinC9;
		p = SinC7 - ((p * u2) >> FracW);
		p = SinC5 - ((p * u2) >> FracW);
		p = SinC3 - ((p * u2) >> FracW);
		p = SinC1 - ((p * u2) >> FracW);
		p = (p * u) >> 30;
		return (p > One) ? One : p;
	endfunction

	function automatic longint unsigned eased_fraction(logic [CmdW-1:0] cmd,
			longint unsigned f);
		longint unsigned g, k;
		int kind, mode, n;
		g = One - f;
		kind = cmd / 3;
		mode = cmd % 3;
		if (cmd == CMD_LINEAR) return f;
		if (kind <= 2) begin
			n = kind + 2;
			k = 64'd1 << (n - 1);
			if (mode == 0) return frac_pow(f, n);
			if (mode == 1) return One - frac_pow(g, n);
			if (f < Half) return k * frac_pow(f, n);
			return One - k * frac_pow(g, n);
		end
		if (kind == 3) begin
			if (mode == 0) return One - quarter_sine(g);
			if (mode == 1) return quarter_sine(f);
			if (f < Half) return (One - quarter_sine(One - 2 * f)) >> 1;
			return (One + quarter_sine(2 * f - One)) >> 1;
		end
		if (mode == 0) return One - frac_sqrt(One - frac_mul(f, f));
		if (mode == 1) return frac_sqrt(One - frac_mul(g, g));
		if (f < Half) return (One - frac_sqrt(One - frac_mul(2 * f, 2 * f))) >> 1;
		return (One + frac_sqrt(One - frac_mul(2 * g, 2 * g))) >> 1;
	endfunction

	function automatic ece_out_t predict_position(ece_in_t item);
		ece_out_t res;
		longint unsigned f, e;
		longint prod, delta, sum;
		res.bad_duration = (item.total_ticks == 0);
		if (item.total_ticks == 0) begin
			e = One;
		end else begin
			f = (item.elapsed_ticks >= item.total_ticks) ? One :
				((longint'(item.elapsed_ticks) << FracW) / item.total_ticks);
			e = eased_fraction(item.command, f);
		end
		prod = longint'(item.span) * longint'(e);
		delta = (prod + longint'(Half)) >>> FracW;
		sum = longint'(item.start_value) + delta;
		res.clipped = 1'b0;
		if (sum > 32767) begin
			sum = 32767;
			res.clipped = 1'b1;
		end else if (sum < -32768) begin
			sum = -32768;
			res.clipped = 1'b1;
		end
		res.eased_value = sum[PosW-1:0];
		return res;
	endfunction

	function automatic ece_in_t random_item(bit full_range);
		ece_in_t it;
		it.command = 4'($urandom_range(0, 15));
		it.start_value = 16'($urandom);
		it.span = 16'($urandom);
		case ($urandom_range(0, 3))
			0: it.total_ticks = 16'($urandom);
			1: it.total_ticks = 16'($urandom_range(1, 300));
			2: it.total_ticks = 16'($urandom_range(0, 3));
			default: it.total_ticks = 16'hFFFF - 16'($urandom_range(0, 5));
		endcase
		if (full_range || $urandom_range(0, 9) == 0)
			it.elapsed_ticks = 16'($urandom);
		else
			it.elapsed_ticks = (it.total_ticks == 0) ? 16'd0 :
				16'($urandom_range(0, it.total_ticks));
		if ($urandom_range(0, 3) == 0) begin
			it.start_value = $urandom_range(0, 1) ? 16'sh7000 : -16'sh7000;
		end
		return it;
	endfunction

	function automatic ece_in_t make_item(logic [CmdW-1:0] cmd, logic [15:0] st,
			logic [15:0] sp, logic [15:0] el, logic [15:0] tot);
		ece_in_t it;
		it.command = cmd;
		it.start_value = st;
		it.span = sp;
		it.elapsed_ticks = el;
		it.total_ticks = tot;
		return it;
	endfunction

	// Clock generation and the single reset.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Input driver: a new item is offered once the previous transfer is done.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) expected_positions.push_back(predict_position(in_data));
			if (!(in_valid && !in_ready)) begin
				if (pending_items.size() > 0 &&
						!(idle_mode == 1 && $urandom_range(0, 99) < 7) &&
						!(idle_mode == 2 && $urandom_range(0, 99) < 81)) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor with random stalls and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		ece_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_positions.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					want = expected_positions.pop_front();
					if (out_data.eased_value !== want.eased_value)
						$display("%0t: eased_value expected %0d actual %0d", $time,
							want.eased_value, out_data.eased_value);
					if (out_data.clipped !== want.clipped)
						$display("%0t: clipped expected %0b actual %0b", $time,
							want.clipped, out_data.clipped);
					if (out_data.bad_duration !== want.bad_duration)
						$display("%0t: bad_duration expected %0b actual %0b", $time,
							want.bad_duration, out_data.bad_duration);
					if (out_data !== want) errors++;
				end
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				out_ready <= 1'b0;
			end else if (idle_mode == 1) begin
				out_ready <= ($urandom_range(0, 99) >= 81);
			end else if (idle_mode == 2) begin
				out_ready <= ($urandom_range(0, 99) >= 7);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WatchdogLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_positions.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [CmdW-1:0] c;
		wait (arst_n === 1'b1);
		// Directed: every curve at the middle of its duration, plus extremes.
		for (int k = 0; k < 16; k++) begin
			c = 4'(k);
			pending_items.push_back(make_item(c, 16'h0000, 16'h1000, 16'd1, 16'd2));
		end
		pending_items.push_back(make_item(CMD_QUAD_IN, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0));
		pending_items.push_back(make_item(CMD_SINE_OUT, 16'h8000, 16'h8000, 16'hFFFF,
			16'd5));
		pending_items.push_back(make_item(CMD_CIRC_IN, 16'h8000, 16'h7FFF, 16'hFFFF,
			16'hFFFF));
		pending_items.push_back(make_item(CMD_CIRC_INOUT, 16'h7FFF, 16'h8000, 16'd0,
			16'hFFFF));
		pending_items.push_back(make_item(CMD_SINE_INOUT, 16'h0000, 16'h8000, 16'd1,
			16'd3));
		pending_items.push_back(make_item(CMD_QURT_INOUT, 16'h7000, 16'h7FFF, 16'd3,
			16'd4));
		pending_items.push_back(make_item(CMD_CUBE_OUT, 16'hFFFF, 16'hFFFF, 16'd100,
			16'd1));
		wait_drained();
		for (int phase = 0; phase < 3; phase++) begin
			idle_mode = (phase == 0) ? 1 : (phase == 1) ? 2 : 0;
			if (phase == 2) hold_off_cycles = 200;
			for (int n = 0; n < 180; n++) pending_items.push_back(random_item(n % 4 == 0));
			wait_drained();
		end
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && expected_positions.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
